// ----- hdl/fspg_pkg.sv -----
// fspg_pkg: constants, stage payload types and shared arithmetic helpers
// for the flame sprite pixel generator; no dependencies
package fspg_pkg;

  localparam int unsigned RowMax     = 63;   // bottom row, h = RowMax - row
  localparam int unsigned CenterCol  = 16;
  localparam int unsigned FullLevel  = 255;
  localparam int unsigned FadeStart  = 10;   // h below this is full level
  localparam int unsigned FadeEnd    = 42;   // h at or above this is dark
  localparam int unsigned FadeShift  = 5;    // fade slope is 255 / 32
  localparam int unsigned WidthMax   = 13;
  localparam int unsigned WidthSteps = 12;
  // h * 12 / 42 == (h * 294) >> 10 for h in 0..63
  localparam int unsigned WidthRecip = 294;
  localparam int unsigned WidthShift = 10;
  localparam int unsigned HashColMul = 7;
  localparam int unsigned HashRowMul = 13;
  localparam logic [31:0] HashMul    = 32'd2654435761;
  localparam int unsigned EdgeBand   = 4;
  // x / 3 == (x * 171) >> 9 for 8-bit x
  localparam int unsigned ThirdRecip = 171;
  localparam int unsigned ThirdShift = 9;
  localparam int unsigned Thresh     = 20;
  localparam int unsigned BaseLevel  = 220;
  localparam int unsigned SpanLevel  = 35;

  localparam int unsigned QuotBits        = 8;
  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned NumDivStages    = QuotBits / DivBitsPerStage;

  // geometry and hash results handed to the divider
  typedef struct packed {
    logic        kill;       // outside the flame, pixel is transparent
    logic        near_edge;  // within the flicker band of the edge
    logic [7:0]  v;          // vertical level
    logic [15:0] num;        // d*d*255
    logic [7:0]  den;        // w*w
    logic [7:0]  hbyte;      // top byte of the flicker hash
  } geo_t;

  // one stage of the restoring divider
  typedef struct packed {
    logic        kill;
    logic [7:0]  v;
    logic [7:0]  n;          // flicker noise
    logic [15:0] rem;
    logic [7:0]  den;
    logic [7:0]  q;
  } div_t;

  // floor(x / 255) for x up to 65279
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  // DivBitsPerStage quotient bits, msb first, starting at bit top
  function automatic div_t div_step(div_t s, logic [2:0] top);
    div_t        r;
    logic [2:0]  b;
    logic [15:0] sh;
    logic        take;
    r = s;
    for (int unsigned j = 0; j < DivBitsPerStage; j++) begin
      b    = top - 3'(j);
      sh   = 16'(r.den) << b;
      take = (r.rem >= sh);
      if (take) begin
        r.rem = r.rem - sh;
      end
      r.q = {r.q[6:0], take};
    end
    return r;
  endfunction

endpackage

// ----- hdl/fspg_front.sv -----
// fspg_front: two pipeline stages, sprite geometry then squares and hash
// depends on fspg_pkg
module fspg_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [8:0]         phase_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [4:0]         column_i,
  input  logic [5:0]         row_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fspg_pkg::geo_t     out_o
);

  // stage a: height, distance, vertical level, half width, hash sum
  logic [5:0]  h_a;
  logic [4:0]  dist_a;
  logic [12:0] fall_a;
  logic [7:0]  lvl_a;
  logic [14:0] sprod_a;
  logic [4:0]  s_a;
  logic [3:0]  w_a;
  logic [10:0] hsum_a;

  logic        vld_a_q, vld_b_q;
  logic        en_a, en_b;
  logic        kill_a_d, kill_a_q;
  logic [4:0]  dist_a_q;
  logic [3:0]  w_a_q;
  logic [7:0]  lvl_a_q;
  logic [10:0] hsum_a_q;

  // stage b
  logic [8:0]  dd_b;
  logic [31:0] hash_b;
  fspg_pkg::geo_t geo_b_d, geo_b_q;

  assign en_b       = !vld_b_q || out_ready_i;
  assign en_a       = !vld_a_q || en_b;
  assign in_ready_o = en_a;

  always_comb begin
    h_a     = 6'(fspg_pkg::RowMax) - row_i;
    dist_a  = (column_i >= 5'(fspg_pkg::CenterCol)) ? column_i - 5'(fspg_pkg::CenterCol)
                                                    : 5'(fspg_pkg::CenterCol) - column_i;
    fall_a  = 13'(h_a - 6'(fspg_pkg::FadeStart)) * 13'(fspg_pkg::FullLevel);
    if (h_a < 6'(fspg_pkg::FadeStart)) begin
      lvl_a = 8'(fspg_pkg::FullLevel);
    end else if (h_a < 6'(fspg_pkg::FadeEnd)) begin
      lvl_a = 8'(fspg_pkg::FullLevel) - 8'(fall_a >> fspg_pkg::FadeShift);
    end else begin
      lvl_a = 8'd0;
    end
    sprod_a = 15'(h_a) * 15'(fspg_pkg::WidthRecip);
    s_a     = 5'(sprod_a >> fspg_pkg::WidthShift);
    w_a     = (s_a >= 5'(fspg_pkg::WidthSteps)) ? 4'd1 : 4'(5'(fspg_pkg::WidthMax) - s_a);
    hsum_a  = 11'(column_i) * 11'(fspg_pkg::HashColMul)
            + 11'(h_a) * 11'(fspg_pkg::HashRowMul) + 11'(phase_i);
    kill_a_d = (dist_a > {1'b0, w_a}) || (lvl_a == 8'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (en_a) begin
      vld_a_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      kill_a_q <= kill_a_d;
      dist_a_q <= dist_a;
      w_a_q    <= w_a;
      lvl_a_q  <= lvl_a;
      hsum_a_q <= hsum_a;
    end
  end

  always_comb begin
    dd_b              = 9'(dist_a_q) * 9'(dist_a_q);
    hash_b            = 32'(hsum_a_q) * fspg_pkg::HashMul;
    geo_b_d.kill      = kill_a_q;
    geo_b_d.near_edge = (({1'b0, w_a_q} - dist_a_q) < 5'(fspg_pkg::EdgeBand));
    geo_b_d.v         = lvl_a_q;
    geo_b_d.num       = 16'(dd_b) * 16'(fspg_pkg::FullLevel);
    geo_b_d.den       = 8'(w_a_q) * 8'(w_a_q);
    geo_b_d.hbyte     = hash_b[31:24];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else if (en_b) begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      geo_b_q <= geo_b_d;
    end
  end

  assign out_valid_o = vld_b_q;
  assign out_o       = geo_b_q;

endmodule

// ----- hdl/fspg_div.sv -----
// fspg_div: pipelined restoring divider for d*d*255 / (w*w), plus noise scale
// depends on fspg_pkg
module fspg_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fspg_pkg::geo_t     in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fspg_pkg::div_t     out_o
);

  localparam int unsigned N = fspg_pkg::NumDivStages;

  fspg_pkg::div_t stg_d [N];
  fspg_pkg::div_t stg_q [N];
  logic [N-1:0]   vld_q;
  logic [N:0]     en;
  fspg_pkg::div_t init;
  logic [15:0]    third;

  always_comb begin
    en[N] = out_ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_comb begin
    third     = 16'(in_i.hbyte) * 16'(fspg_pkg::ThirdRecip);
    init.kill = in_i.kill;
    init.v    = in_i.v;
    init.n    = in_i.near_edge ? 8'(third >> fspg_pkg::ThirdShift) : 8'd0;
    init.rem  = in_i.num;
    init.den  = in_i.den;
    init.q    = 8'd0;
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < N; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [2:0] Top = 3'(fspg_pkg::QuotBits - 1 - k * fspg_pkg::DivBitsPerStage);

    always_comb begin
      if (k == 0) begin
        stg_d[k] = fspg_pkg::div_step(init, Top);
      end else begin
        stg_d[k] = fspg_pkg::div_step(stg_q[(k == 0) ? 0 : k - 1], Top);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign out_valid_o = vld_q[N-1];
  assign out_o       = stg_q[N-1];

endmodule

// ----- hdl/fspg_back.sv -----
// fspg_back: three pipeline stages, level product, noise subtract, threshold
// depends on fspg_pkg
module fspg_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fspg_pkg::div_t     in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         intensity_o
);

  logic        en_c, en_d, en_e;
  logic        vld_c_q, vld_d_q, vld_e_q;

  logic [7:0]  hz_c;
  logic [15:0] prod_c_d, prod_c_q;
  logic        kill_c_q;
  logic [7:0]  n_c_q;

  logic [7:0]  p_d;
  logic [7:0]  raw_d_d, raw_d_q;

  logic [15:0] span_e;
  logic [7:0]  res_e_d, res_e_q;

  assign en_e       = !vld_e_q || out_ready_i;
  assign en_d       = !vld_d_q || en_e;
  assign en_c       = !vld_c_q || en_d;
  assign in_ready_o = en_c;

  // stage c: vertical level times horizontal falloff
  always_comb begin
    hz_c     = 8'(fspg_pkg::FullLevel) - in_i.q;
    prod_c_d = 16'(in_i.v) * 16'(hz_c);
  end

  // stage d: scale back to 8 bits, subtract flicker with a floor at zero, zero killed pixels
  always_comb begin
    p_d = fspg_pkg::div255(prod_c_q);
    if (!kill_c_q && (p_d > n_c_q)) begin
      raw_d_d = p_d - n_c_q;
    end else begin
      raw_d_d = 8'd0;
    end
  end

  // stage e: hard threshold, then map surviving levels into BaseLevel..BaseLevel+SpanLevel
  always_comb begin
    span_e = 16'(raw_d_q) * 16'(fspg_pkg::SpanLevel);
    if (raw_d_q < 8'(fspg_pkg::Thresh)) begin
      res_e_d = 8'd0;
    end else begin
      res_e_d = 8'(fspg_pkg::BaseLevel) + fspg_pkg::div255(span_e);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
      vld_e_q <= 1'b0;
    end else begin
      if (en_c) begin
        vld_c_q <= in_valid_i;
      end
      if (en_d) begin
        vld_d_q <= vld_c_q;
      end
      if (en_e) begin
        vld_e_q <= vld_d_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      prod_c_q <= prod_c_d;
      kill_c_q <= in_i.kill;
      n_c_q    <= in_i.n;
    end
    if (en_d) begin
      raw_d_q <= raw_d_d;
    end
    if (en_e) begin
      res_e_q <= res_e_d;
    end
  end

  assign out_valid_o = vld_e_q;
  assign intensity_o = res_e_q;

endmodule

// ----- hdl/flame_sprite_pixel_generator_top.sv -----
// flame_sprite_pixel_generator_top: nine-stage pixel pipeline and phase register
// depends on fspg_pkg, fspg_front, fspg_div, fspg_back
// throughput: one pixel per cycle while out_ready_i is high, set by the nine register
//   stages, each stage advancing whenever it is empty or the stage after it moves
// reset: rst_ni clears all stage valid bits and the noise phase to 0
module flame_sprite_pixel_generator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  // noise phase register
  input  logic       noise_phase_we_i,
  input  logic [8:0] noise_phase_i,
  // pixel coordinate channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [4:0] column_i,
  input  logic [5:0] row_i,
  // intensity channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] intensity_o
);

  // phase must only be written while the pipeline is empty; the block does not enforce it
  logic [8:0] phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 9'd0;
    end else if (noise_phase_we_i) begin
      phase_q <= noise_phase_i;
    end
  end

  // front to divider
  logic           geo_valid, geo_ready;
  fspg_pkg::geo_t geo;
  // divider to back end
  logic           div_valid, div_ready;
  fspg_pkg::div_t quo;

  // stages 1-2: height, distance, fade level, half width, squares, hash
  fspg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .phase_i     (phase_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .column_i    (column_i),
    .row_i       (row_i),
    .out_valid_o (geo_valid),
    .out_ready_i (geo_ready),
    .out_o       (geo)
  );

  // stages 3-6: two quotient bits per stage for the horizontal falloff
  fspg_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (geo_valid),
    .in_ready_o  (geo_ready),
    .in_i        (geo),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_o       (quo)
  );

  // stages 7-9: product, flicker subtract, threshold; stage 9 is the output register
  fspg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .in_i        (quo),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .intensity_o (intensity_o)
  );

endmodule

// ----- hdl/fspg_checker.sv -----
// fspg_checker: port-level assertions for the flame sprite pixel generator
// bound to flame_sprite_pixel_generator_top; no package dependency
module fspg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] intensity_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(intensity_o))
    else $error("stalled result changed or dropped");

  // thresholding leaves no level between transparent and the base level
  a_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (intensity_o == 8'd0) || (intensity_o >= 8'd220))
    else $error("intensity inside the thresholded gap");

  // input backpressure only when the output is stalled on a result
  a_bp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input not ready without an output stall");

  // no result right after a reset edge
  a_rst: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind flame_sprite_pixel_generator_top fspg_checker u_fspg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .intensity_o (intensity_o)
);
